/* hw/rtl/dssf_pkg.sv */
`default_nettype none

package dssf_pkg;

   // field widths
   localparam int VOL_W   = 24;
   localparam int PRICE_W = 16;
   localparam int TOT_W   = 40;
   localparam int POS_W   = 5;
   localparam int SEG_W   = 8;

   // binary to decimal conversion: every row shifts its own 40-bit source
   localparam int CONV_BITS  = 40;
   localparam int STEP_BITS  = 4;
   localparam int CONV_STEPS = CONV_BITS / STEP_BITS;
   localparam int STEP_CNT_W = $clog2(CONV_STEPS);

   localparam int TOT_DIGITS   = 13;
   localparam int VOL_DIGITS   = 8;
   localparam int PRICE_DIGITS = 5;

   // frame layout
   localparam int SECT_DIGITS = 6;
   localparam int UNIT_DIGITS = 4;
   localparam int TOTAL_DROP  = 2;
   localparam int FRAME_SLOTS = 16;
   localparam int PUMP_SLOTS  = 16;
   localparam int TOTAL_SLOTS = 15;
   localparam int SLOT_CNT_W  = $clog2(FRAME_SLOTS + 1);

   localparam int POS_VOL_FIRST   = 6;
   localparam int POS_UNIT_FIRST  = 25;
   localparam int POS_PRICE_POINT = 27;
   localparam int POS_UNIT_LAST   = 28;
   localparam int POS_VOL_POINT   = 9;
   localparam int POS_TOTAL_POINT = 16;
   localparam int POS_TOT_POINT   = 8;

   localparam logic [SEG_W-1:0] SEG_BLANK   = 8'h00;
   localparam logic [SEG_W-1:0] SEG_POINT   = 8'h01;
   localparam logic [SEG_W-1:0] CHAR_UNIT_A = 8'hEE;
   localparam logic [SEG_W-1:0] CHAR_UNIT_B = 8'h2A;
   localparam logic [SEG_W-1:0] CHAR_UNIT_C = 8'h60;

   typedef logic [3:0] bcd_type;

   typedef enum logic {
      OP_PUMP  = 1'b0,
      OP_TOTAL = 1'b1
   } opcode_type;

   typedef struct packed {
      logic load;
      logic step;
   } row_ctl_type;

   function automatic logic [SEG_W-1:0] seg_of_digit(input bcd_type d);
      logic [SEG_W-1:0] c;
      case (d)
         4'd0:    c = 8'hFC;
         4'd1:    c = 8'h60;
         4'd2:    c = 8'hDA;
         4'd3:    c = 8'hF2;
         4'd4:    c = 8'h66;
         4'd5:    c = 8'hB6;
         4'd6:    c = 8'hBE;
         4'd7:    c = 8'hE0;
         4'd8:    c = 8'hFE;
         4'd9:    c = 8'hF6;
         default: c = SEG_BLANK;
      endcase
      return c;
   endfunction

   // lit is low once everything from this digit up is zero
   function automatic logic [SEG_W-1:0] digit_code(input bcd_type d, input logic lit,
                                                   input logic pt);
      logic [SEG_W-1:0] c;
      c = seg_of_digit(d);
      if (pt) begin
         c = c | SEG_POINT;
      end
      return lit ? c : SEG_BLANK;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/dssf_ifs.sv */
`default_nettype none

interface dssf_req_if;
   import dssf_pkg::*;

   logic                 valid;
   logic                 ready;
   opcode_type           opcode;
   logic [VOL_W-1:0]     volume_hundredths;
   logic [PRICE_W-1:0]   price_tenths;
   logic [TOT_W-1:0]     totalizer_thousandths;

   modport source (output valid, output opcode, output volume_hundredths,
                   output price_tenths, output totalizer_thousandths, input ready);
   modport sink   (input valid, input opcode, input volume_hundredths,
                   input price_tenths, input totalizer_thousandths, output ready);
endinterface

interface dssf_rsp_if;
   import dssf_pkg::*;

   logic               valid;
   logic               ready;
   logic [POS_W-1:0]   position;
   logic [SEG_W-1:0]   segment_code;
   logic               last;

   modport source (output valid, output position, output segment_code, output last,
                   input ready);
   modport sink   (input valid, input position, input segment_code, input last,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/dssf_digit_cell.sv */
`default_nettype none

// One BCD digit of a shift-add-3 converter. While step is high it takes STEP
// bits per cycle from the lower neighbor and hands STEP bits to the upper one.
module dssf_digit_cell #(
   parameter int STEP = dssf_pkg::STEP_BITS
) (
   input  logic              clock,
   input  logic              clear,
   input  logic              step,
   input  logic [STEP-1:0]   shift_in,
   output logic [STEP-1:0]   shift_out,
   output dssf_pkg::bcd_type digit
);
   import dssf_pkg::*;

   bcd_type digit_ff;
   bcd_type digit_in;

   // first bit to enter is shift_in[STEP-1]
   always_comb begin
      bcd_type work;
      work = digit_ff;
      shift_out = '0;
      for (int j = STEP - 1; j >= 0; j--) begin
         if (work >= 4'd5) begin
            work = work + 4'd3;
         end
         shift_out[j] = work[3];
         work = {work[2:0], shift_in[j]};
      end
      digit_in = work;
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         digit_ff <= '0;
      end else if (step) begin
         digit_ff <= digit_in;
      end
   end

   assign digit = digit_ff;

endmodule

`default_nettype wire

/* hw/rtl/dssf_digit_row.sv */
`default_nettype none

// Source shifter feeding a chain of digit cells, MSB first.
module dssf_digit_row #(
   parameter int NUM_DIGITS = dssf_pkg::TOT_DIGITS,
   parameter int SRC_WIDTH  = dssf_pkg::CONV_BITS,
   parameter int STEP       = dssf_pkg::STEP_BITS
) (
   input  logic                                   clock,
   input  dssf_pkg::row_ctl_type                  ctl,
   input  logic [SRC_WIDTH-1:0]                   value,
   output dssf_pkg::bcd_type [NUM_DIGITS-1:0]     digits,
   output logic [STEP-1:0]                        spill
);
   import dssf_pkg::*;

   logic [SRC_WIDTH-1:0] src_ff;
   logic [SRC_WIDTH-1:0] src_in;
   logic [NUM_DIGITS:0][STEP-1:0] link;

   assign src_in  = {src_ff[SRC_WIDTH-STEP-1:0], {STEP{1'b0}}};
   assign link[0] = src_ff[SRC_WIDTH-1 -: STEP];
   assign spill   = link[NUM_DIGITS];

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         src_ff <= value;
      end else if (ctl.step) begin
         src_ff <= src_in;
      end
   end

   for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
      dssf_digit_cell #(
         .STEP (STEP)
      ) u_cell (
         .clock     (clock),
         .clear     (ctl.load),
         .step      (ctl.step),
         .shift_in  (link[k]),
         .shift_out (link[k+1]),
         .digit     (digits[k])
      );
   end

endmodule

`default_nettype wire

/* hw/rtl/dssf_frame_queue.sv */
`default_nettype none

// Builds the frame bytes of one readout from the decimal digits and shifts
// them out, lowest position first.
module dssf_frame_queue (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  dssf_pkg::opcode_type                          opcode,
   input  dssf_pkg::bcd_type [dssf_pkg::TOT_DIGITS-1:0]  big_digits,
   input  dssf_pkg::bcd_type [dssf_pkg::VOL_DIGITS-1:0]  vol_digits,
   input  dssf_pkg::bcd_type [dssf_pkg::PRICE_DIGITS-1:0] price_digits,
   output logic                                          can_load,
   dssf_rsp_if.source                                    rsp
);
   import dssf_pkg::*;

   localparam int UNIT_SLOT = 2 * SECT_DIGITS;

   logic [SEG_W-1:0]      code_ff  [FRAME_SLOTS];
   logic [SEG_W-1:0]      code_in  [FRAME_SLOTS];
   logic [POS_W-1:0]      pos_ff   [FRAME_SLOTS];
   logic [POS_W-1:0]      pos_in   [FRAME_SLOTS];
   logic [SEG_W-1:0]      fill_code[FRAME_SLOTS];
   logic [POS_W-1:0]      fill_pos [FRAME_SLOTS];
   logic [SLOT_CNT_W-1:0] cnt_ff;
   logic [SLOT_CNT_W-1:0] cnt_in;
   logic [TOT_DIGITS-1:0]   big_lit;
   logic [VOL_DIGITS-1:0]   vol_lit;
   logic [PRICE_DIGITS-1:0] price_lit;
   logic                    pop;

   assign pop      = rsp.valid & rsp.ready;
   assign can_load = (cnt_ff == '0) || ((cnt_ff == SLOT_CNT_W'(1)) && pop);

   // a digit shows while anything from it upward is nonzero
   always_comb begin
      big_lit[TOT_DIGITS-1] = big_digits[TOT_DIGITS-1] != 4'd0;
      for (int k = TOT_DIGITS - 2; k >= 0; k--) begin
         big_lit[k] = big_lit[k+1] | (big_digits[k] != 4'd0);
      end
      vol_lit[VOL_DIGITS-1] = vol_digits[VOL_DIGITS-1] != 4'd0;
      for (int k = VOL_DIGITS - 2; k >= 0; k--) begin
         vol_lit[k] = vol_lit[k+1] | (vol_digits[k] != 4'd0);
      end
      price_lit[PRICE_DIGITS-1] = price_digits[PRICE_DIGITS-1] != 4'd0;
      for (int k = PRICE_DIGITS - 2; k >= 0; k--) begin
         price_lit[k] = price_lit[k+1] | (price_digits[k] != 4'd0);
      end
   end

   always_comb begin
      for (int e = 0; e < SECT_DIGITS; e++) begin
         fill_pos[e] = POS_W'(POS_VOL_FIRST + e);
         if (opcode == OP_TOTAL) begin
            fill_code[e] = digit_code(big_digits[SECT_DIGITS-1-e], big_lit[SECT_DIGITS-1-e],
                                      fill_pos[e] == POS_W'(POS_TOT_POINT));
         end else begin
            fill_code[e] = digit_code(vol_digits[SECT_DIGITS-1-e], vol_lit[SECT_DIGITS-1-e],
                                      fill_pos[e] == POS_W'(POS_VOL_POINT));
         end
      end
      for (int e = SECT_DIGITS; e < 2 * SECT_DIGITS; e++) begin
         fill_pos[e] = POS_W'(POS_VOL_FIRST + e);
         if (opcode == OP_TOTAL) begin
            // totalizer quotient carries on past the volume section, no point
            fill_code[e] = digit_code(big_digits[3*SECT_DIGITS-1-e],
                                      big_lit[3*SECT_DIGITS-1-e], 1'b0);
         end else begin
            // money total: drop two digits of the product for the /100
            fill_code[e] = digit_code(big_digits[TOTAL_DROP+2*SECT_DIGITS-1-e],
                                      big_lit[TOTAL_DROP+2*SECT_DIGITS-1-e],
                                      fill_pos[e] == POS_W'(POS_TOTAL_POINT));
         end
      end
      for (int u = 0; u < UNIT_DIGITS; u++) begin
         fill_pos[UNIT_SLOT+u]  = POS_W'(POS_UNIT_FIRST + u);
         fill_code[UNIT_SLOT+u] = digit_code(price_digits[UNIT_DIGITS-1-u],
                                             price_lit[UNIT_DIGITS-1-u],
                                             fill_pos[UNIT_SLOT+u] ==
                                             POS_W'(POS_PRICE_POINT));
      end
      if (opcode == OP_TOTAL) begin
         // fixed unit characters, second unit position skipped
         fill_pos[UNIT_SLOT]    = POS_W'(POS_UNIT_FIRST);
         fill_code[UNIT_SLOT]   = CHAR_UNIT_A;
         fill_pos[UNIT_SLOT+1]  = POS_W'(POS_PRICE_POINT);
         fill_code[UNIT_SLOT+1] = CHAR_UNIT_B;
         fill_pos[UNIT_SLOT+2]  = POS_W'(POS_UNIT_LAST);
         fill_code[UNIT_SLOT+2] = CHAR_UNIT_C;
      end
   end

   always_comb begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         code_in[i] = code_ff[i];
         pos_in[i]  = pos_ff[i];
         if (load) begin
            code_in[i] = fill_code[i];
            pos_in[i]  = fill_pos[i];
         end else if (pop && (i < FRAME_SLOTS - 1)) begin
            code_in[i] = code_ff[(i + 1) % FRAME_SLOTS];
            pos_in[i]  = pos_ff[(i + 1) % FRAME_SLOTS];
         end
      end
      cnt_in = cnt_ff;
      if (load) begin
         cnt_in = (opcode == OP_TOTAL) ? SLOT_CNT_W'(TOTAL_SLOTS) : SLOT_CNT_W'(PUMP_SLOTS);
      end else if (pop) begin
         cnt_in = cnt_ff - SLOT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         code_ff[i] <= code_in[i];
         pos_ff[i]  <= pos_in[i];
      end
   end

   assign rsp.valid        = cnt_ff != '0;
   assign rsp.position     = pos_ff[0];
   assign rsp.segment_code = code_ff[0];
   assign rsp.last         = cnt_ff == SLOT_CNT_W'(1);

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> (cnt_ff == SLOT_CNT_W'(PUMP_SLOTS)) || (cnt_ff == SLOT_CNT_W'(TOTAL_SLOTS)))
      else $error("frame queue loaded with wrong byte count");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      pop && rsp.last && !load |=> cnt_ff == '0)
      else $error("frame queue not empty after last transaction");

endmodule

`default_nettype wire

/* hw/rtl/decimal_seven_segment_formatter.sv */
// Flow: an accepted readout converts in the digit rows, waits in CV_DONE until
// the output queue can load it, then shows its first byte. One byte per cycle
// while rsp_ch.ready is high; 16 bytes a readout (pump) or 15 (totalizer). The
// next readout converts (4 bits a cycle) in the digit rows as the queue drains.
// Reset: synchronous, active high; clears the converter state and empties the
// output queue. No clearing pass.
`default_nettype none

module decimal_seven_segment_formatter (
   input  logic      clock,
   input  logic      reset,
   dssf_req_if.sink  req_ch,
   dssf_rsp_if.source rsp_ch
);
   import dssf_pkg::*;

   typedef enum logic [2:0] {
      CV_IDLE = 3'b001,
      CV_RUN  = 3'b010,
      CV_DONE = 3'b100
   } conv_state_type;

   conv_state_type          state_ff;
   conv_state_type          state_in;
   logic [STEP_CNT_W-1:0]   step_cnt_ff;
   logic [STEP_CNT_W-1:0]   step_cnt_in;
   opcode_type              opcode_ff;
   logic                    accept;
   logic                    xfer;
   logic                    can_load;
   row_ctl_type             ctl;
   logic [VOL_W+PRICE_W-1:0] product;
   logic [CONV_BITS-1:0]    big_value;
   logic [CONV_BITS-1:0]    vol_value;
   logic [CONV_BITS-1:0]    price_value;
   logic [STEP_BITS-1:0]    big_spill;
   logic [STEP_BITS-1:0]    vol_spill;
   logic [STEP_BITS-1:0]    price_spill;
   bcd_type [TOT_DIGITS-1:0]   big_digits;
   bcd_type [VOL_DIGITS-1:0]   vol_digits;
   bcd_type [PRICE_DIGITS-1:0] price_digits;

   assign product     = (VOL_W+PRICE_W)'(req_ch.volume_hundredths) *
                        (VOL_W+PRICE_W)'(req_ch.price_tenths);
   assign big_value   = (req_ch.opcode == OP_TOTAL) ? req_ch.totalizer_thousandths : product;
   assign vol_value   = CONV_BITS'(req_ch.volume_hundredths);
   assign price_value = CONV_BITS'(req_ch.price_tenths);

   assign xfer         = (state_ff == CV_DONE) && can_load;
   assign req_ch.ready = (state_ff == CV_IDLE) || xfer;
   assign accept       = req_ch.valid & req_ch.ready;
   assign ctl.load     = accept;
   assign ctl.step     = state_ff == CV_RUN;

   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      case (state_ff)
         CV_IDLE: begin
            if (accept) begin
               state_in = CV_RUN;
            end
         end
         CV_RUN: begin
            if (step_cnt_ff == STEP_CNT_W'(CONV_STEPS - 1)) begin
               state_in = CV_DONE;
            end
         end
         CV_DONE: begin
            if (xfer) begin
               state_in = accept ? CV_RUN : CV_IDLE;
            end
         end
         default: begin
            state_in = CV_IDLE;
         end
      endcase
      if (accept) begin
         step_cnt_in = '0;
      end else if (state_ff == CV_RUN) begin
         step_cnt_in = step_cnt_ff + STEP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_cnt_ff <= step_cnt_in;
      if (accept) begin
         opcode_ff <= req_ch.opcode;
      end
   end

   // product in pump mode, totalizer otherwise
   dssf_digit_row #(
      .NUM_DIGITS (TOT_DIGITS),
      .SRC_WIDTH  (CONV_BITS),
      .STEP       (STEP_BITS)
   ) u_big_row (
      .clock  (clock),
      .ctl    (ctl),
      .value  (big_value),
      .digits (big_digits),
      .spill  (big_spill)
   );

   dssf_digit_row #(
      .NUM_DIGITS (VOL_DIGITS),
      .SRC_WIDTH  (CONV_BITS),
      .STEP       (STEP_BITS)
   ) u_vol_row (
      .clock  (clock),
      .ctl    (ctl),
      .value  (vol_value),
      .digits (vol_digits),
      .spill  (vol_spill)
   );

   dssf_digit_row #(
      .NUM_DIGITS (PRICE_DIGITS),
      .SRC_WIDTH  (CONV_BITS),
      .STEP       (STEP_BITS)
   ) u_price_row (
      .clock  (clock),
      .ctl    (ctl),
      .value  (price_value),
      .digits (price_digits),
      .spill  (price_spill)
   );

   dssf_frame_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .load         (xfer),
      .opcode       (opcode_ff),
      .big_digits   (big_digits),
      .vol_digits   (vol_digits),
      .price_digits (price_digits),
      .can_load     (can_load),
      .rsp          (rsp_ch)
   );

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == CV_RUN |-> !req_ch.ready)
      else $error("transaction accepted during conversion");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == CV_RUN) && (step_cnt_ff == '0))
      else $error("conversion did not start after accept");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CV_DONE) && !xfer |=> state_ff == CV_DONE)
      else $error("converted digits lost before hand-off");

   a_no_spill: assert property (@(posedge clock) disable iff (reset)
      ctl.step |-> (big_spill == '0) && (vol_spill == '0) && (price_spill == '0))
      else $error("digit row overflow");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
   import dssf_pkg::*;

   localparam int VOL_LO = POS_VOL_FIRST;
   localparam int VOL_HI = VOL_LO + SECT_DIGITS - 1;
   localparam int SUM_LO = VOL_HI + 1;
   localparam int SUM_HI = SUM_LO + SECT_DIGITS - 1;
   localparam int NO_POINT_POS = 0;
   localparam int RANDOM_READOUTS = 108;
   localparam int HOLD_AT_BYTE = 400;
   localparam int HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [SEG_W-1:0] DIGIT_SEG [10] = '{
      8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
   };

   typedef struct packed {
      opcode_type             op;
      logic [VOL_W-1:0]       vol;
      logic [PRICE_W-1:0]     price;
      logic [TOT_W-1:0]       tot;
      logic                   typed;
      logic [15:0][SEG_W-1:0] codes;   // slot i in codes[i], used when typed
   } readout_row_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [SEG_W-1:0] segment_code;
      logic             last;
   } seg_byte_type;

   localparam int DIRECTED_ROWS = 22;
   localparam readout_row_type DIRECTED [DIRECTED_ROWS] = '{
      // blank frames and a frame with one lit digit in volume and in price: codes typed in
      '{OP_PUMP,  24'd0, 16'd0, 40'd0, 1'b1, 128'h0},
      '{OP_TOTAL, 24'd0, 16'd0, 40'd0, 1'b1,
        128'h00_60_2A_EE_00_00_00_00_00_00_00_00_00_00_00_00},
      '{OP_PUMP,  24'd1, 16'd1, 40'd0, 1'b1,
        128'h60_00_00_00_00_00_00_00_00_00_60_00_00_00_00_00},
      // totalizer point lit on position 8
      '{OP_TOTAL, 24'd0, 16'd0, 40'd1000, 1'b1,
        128'h00_60_2A_EE_00_00_00_00_00_00_FC_FC_FC_61_00_00},
      '{OP_PUMP,  24'hFFFFFF, 16'hFFFF, 40'd0, 1'b0, 128'h0},
      '{OP_TOTAL, 24'd0, 16'd0, 40'hFF_FFFF_FFFF, 1'b0, 128'h0},
      '{OP_PUMP,  24'd999999, 16'd9999, 40'd0, 1'b0, 128'h0},
      '{OP_PUMP,  24'd1000000, 16'd10000, 40'd0, 1'b0, 128'h0},
      '{OP_PUMP,  24'd99, 16'd100, 40'd0, 1'b0, 128'h0},
      '{OP_PUMP,  24'd33, 16'd3, 40'd0, 1'b0, 128'h0},
      '{OP_PUMP,  24'd100, 16'd10, 40'd0, 1'b0, 128'h0},
      '{OP_PUMP,  24'd12345678, 16'd12345, 40'd0, 1'b0, 128'h0},
      '{OP_PUMP,  24'd0, 16'd65535, 40'd0, 1'b0, 128'h0},
      '{OP_PUMP,  24'hFFFFFF, 16'd0, 40'd0, 1'b0, 128'h0},
      '{OP_TOTAL, 24'd0, 16'd0, 40'd1, 1'b0, 128'h0},
      '{OP_TOTAL, 24'd0, 16'd0, 40'd100, 1'b0, 128'h0},
      '{OP_TOTAL, 24'd0, 16'd0, 40'd999999999999, 1'b0, 128'h0},
      '{OP_TOTAL, 24'd0, 16'd0, 40'd1000000000000, 1'b0, 128'h0},
      '{OP_TOTAL, 24'h123456, 16'h9876, 40'd123456789012, 1'b0, 128'h0},
      '{OP_PUMP,  24'hAAAAAA, 16'h5555, 40'hAA_AAAA_AAAA, 1'b0, 128'h0},
      '{OP_PUMP,  24'h555555, 16'hAAAA, 40'h55_5555_5555, 1'b0, 128'h0},
      '{OP_TOTAL, 24'hAAAAAA, 16'h5555, 40'hAA_AAAA_AAAA, 1'b0, 128'h0}
   };

   logic clock;
   logic reset;
   int   errors;
   int   bytes_seen;
   seg_byte_type frame_bytes_due [$];

   dssf_req_if req_ch ();
   dssf_rsp_if rsp_ch ();

   decimal_seven_segment_formatter DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("TB_ERROR");
      $finish;
   end

   function automatic int slot_position(input opcode_type op, input int slot);
      if (slot < 2 * SECT_DIGITS) begin
         return POS_VOL_FIRST + slot;
      end
      if (op == OP_PUMP) begin
         return POS_UNIT_FIRST + slot - 2 * SECT_DIGITS;
      end
      // totalizer skips the second unit position
      case (slot - 2 * SECT_DIGITS)
         0:       return POS_UNIT_FIRST;
         1:       return POS_PRICE_POINT;
         default: return POS_UNIT_LAST;
      endcase
   endfunction

   // digits go least significant first from hi down to lo; blank once q runs out
   function automatic void fill_section(inout logic [31:0][SEG_W-1:0] frame,
                                        input int lo, input int hi,
                                        inout logic [TOT_W-1:0] q, input int pt);
      for (int p = hi; p >= lo; p--) begin
         if (q != 0) begin
            frame[p] = DIGIT_SEG[q % 10] | ((p == pt) ? SEG_POINT : SEG_BLANK);
            q = q / 10;
         end else begin
            frame[p] = SEG_BLANK;
         end
      end
   endfunction

   function automatic void format_readout(input readout_row_type r);
      logic [31:0][SEG_W-1:0] frame;
      logic [TOT_W-1:0]       q;
      int                     n;
      int                     pos;
      frame = '0;
      if (r.op == OP_PUMP) begin
         q = TOT_W'(r.vol);
         fill_section(frame, VOL_LO, VOL_HI, q, POS_VOL_POINT);
         q = (TOT_W'(r.vol) * TOT_W'(r.price)) / 100;
         fill_section(frame, SUM_LO, SUM_HI, q, POS_TOTAL_POINT);
         q = TOT_W'(r.price);
         fill_section(frame, POS_UNIT_FIRST, POS_UNIT_LAST, q, POS_PRICE_POINT);
         n = PUMP_SLOTS;
      end else begin
         q = r.tot;
         fill_section(frame, VOL_LO, VOL_HI, q, POS_TOT_POINT);
         fill_section(frame, SUM_LO, SUM_HI, q, NO_POINT_POS);
         frame[POS_UNIT_FIRST]  = CHAR_UNIT_A;
         frame[POS_PRICE_POINT] = CHAR_UNIT_B;
         frame[POS_UNIT_LAST]   = CHAR_UNIT_C;
         n = TOTAL_SLOTS;
      end
      for (int i = 0; i < n; i++) begin
         pos = slot_position(r.op, i);
         frame_bytes_due.push_back('{POS_W'(pos), r.typed ? r.codes[i] : frame[pos],
                                     1'(i == n - 1)});
      end
   endfunction

   // called at a rising edge; returns at the edge where the transaction is taken
   task automatic send_readout(input readout_row_type r, input int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid                 <= 1'b1;
      req_ch.opcode                <= r.op;
      req_ch.volume_hundredths     <= r.vol;
      req_ch.price_tenths          <= r.price;
      req_ch.totalizer_thousandths <= r.tot;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      format_readout(r);
   endtask

   // stimulus
   initial begin
      readout_row_type r;
      int              gap;
      errors = 0;
      reset                        <= 1'b1;
      req_ch.valid                 <= 1'b0;
      req_ch.opcode                <= OP_PUMP;
      req_ch.volume_hundredths     <= '0;
      req_ch.price_tenths          <= '0;
      req_ch.totalizer_thousandths <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_readout(DIRECTED[i], $urandom_range(0, 3));
      end

      // let the block drain completely before the random part
      req_ch.valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);

      for (int i = 0; i < RANDOM_READOUTS; i++) begin
         r       = '0;
         r.op    = $urandom_range(0, 1) ? OP_TOTAL : OP_PUMP;
         // random magnitude so short values and blanking show up often
         r.vol   = VOL_W'($urandom) >> $urandom_range(0, VOL_W - 1);
         r.price = PRICE_W'($urandom) >> $urandom_range(0, PRICE_W - 1);
         r.tot   = {8'($urandom), 32'($urandom)} >> $urandom_range(0, TOT_W - 1);
         gap     = ((i / 16) % 3 == 0) ? 0 : $urandom_range(0, 3);
         send_readout(r, gap);
      end
      req_ch.valid <= 1'b0;

      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off, transaction checks
   initial begin
      seg_byte_type want;
      int           wait_cycles;
      bytes_seen = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (bytes_seen == HOLD_AT_BYTE) begin
            wait_cycles = HOLD_CYCLES;
         end else if ((bytes_seen / 64) % 3 == 1) begin
            wait_cycles = 0;
         end else begin
            wait_cycles = $urandom_range(0, 3);
         end
         if (wait_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         bytes_seen++;
         if (frame_bytes_due.size() == 0) begin
            $error("unexpected byte: position %0d segment_code %h last %b",
                   rsp_ch.position, rsp_ch.segment_code, rsp_ch.last);
            errors++;
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_ch.position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_ch.position);
               errors++;
            end
            if (rsp_ch.segment_code !== want.segment_code) begin
               $error("segment_code (position %0d): expected %h, got %h",
                      want.position, want.segment_code, rsp_ch.segment_code);
               errors++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last (position %0d): expected %b, got %b",
                      want.position, want.last, rsp_ch.last);
               errors++;
            end
         end
      end
   end

endmodule

/* files.f */
hw/rtl/dssf_pkg.sv
hw/rtl/dssf_ifs.sv
hw/rtl/dssf_digit_cell.sv
hw/rtl/dssf_digit_row.sv
hw/rtl/dssf_frame_queue.sv
hw/rtl/decimal_seven_segment_formatter.sv
test/tb.sv
